@@ hdl/rhw_pkg.sv @@
// shared types and constants for the fp64 high-word reciprocal
// no dependencies
`timescale 1ns / 1ps

package rhw_pkg;

  localparam int MANT_W     = 52;
  localparam int EXP_W      = 11;
  localparam int WORD_W     = 64;
  localparam int LOW_W      = 32;
  localparam int DIV_W      = MANT_W + 1;
  localparam int REM_W      = MANT_W + 2;
  localparam int QUO_W      = MANT_W + 2;
  localparam int NUM_CELLS  = QUO_W;

  localparam logic [EXP_W-1:0] EXP_ONES      = 11'h7FF;
  localparam logic [EXP_W-1:0] EXP_UNIT_BASE = 11'd2046;
  localparam logic [EXP_W-1:0] EXP_FRAC_BASE = 11'd2045;

  typedef struct packed {
    logic              sign;
    logic [EXP_W-1:0]  res_exp;
    logic              special;
    logic [WORD_W-1:0] special_val;
  } rhw_side_t;

  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [DIV_W-1:0]  div;
    logic [QUO_W-1:0]  quo;
    rhw_side_t         side;
  } rhw_work_t;

endpackage

@@ hdl/rhw_cell.sv @@
// one restoring division cell: one quotient bit per cell, registered
// depends on rhw_pkg
`timescale 1ns / 1ps

module rhw_cell
  import rhw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      ce,
  input  rhw_work_t cell_in,
  output rhw_work_t cell_out
);

  logic             valid_r;
  logic             valid_nxt;
  rhw_work_t        data_r;
  rhw_work_t        data_nxt;
  logic [REM_W:0]   diff;
  logic             ge;
  logic [REM_W-1:0] rem_sel;

  always_comb begin
    diff      = {1'b0, cell_in.rem} - {2'b0, cell_in.div};
    ge        = !diff[REM_W];
    rem_sel   = ge ? diff[REM_W-1:0] : cell_in.rem;
    data_nxt       = cell_in;
    data_nxt.rem   = {rem_sel[REM_W-2:0], 1'b0};
    data_nxt.quo   = {cell_in.quo[QUO_W-2:0], ge};
    valid_nxt      = ce ? cell_in.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    cell_out       = data_r;
    cell_out.valid = valid_r;
  end

endmodule

@@ hdl/fp64_reciprocal_high_word.sv @@
// fp64 reciprocal, high word only: operand decode, division cell chain, rounding
// depends on rhw_pkg and rhw_cell
`timescale 1ns / 1ps

// usage:
//   in_valid/in_operand_bits carry one binary64 word; it is taken at a clock
//   edge where in_valid is high and in_stall is low.
//   out_valid/out_result_bits return 1/x rounded to nearest (ties up), low 32 bits
//   cleared; nan returns its bits with sign cleared, zero or subnormal gives
//   signed infinity, infinity gives signed zero, tiny results give signed zero.
// pipeline: 54 division cells, one bit each, then the rounding output register.
// throughput: one word per cycle unless stalled; the whole chain advances together.
// stall: while out_valid is high and out_stall is high the chain holds and
//   in_stall is raised; words already inside are kept, none are lost.
// reset: rst_n low clears every valid bit; no words are in flight afterwards.

module fp64_reciprocal_high_word
  import rhw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] in_operand_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_result_bits
);

  logic              ce;
  rhw_work_t         front;
  rhw_work_t         chain [NUM_CELLS+1];
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_data_r;
  logic [WORD_W-1:0] out_data_nxt;

  logic              op_sign;
  logic [EXP_W-1:0]  op_exp;
  logic [MANT_W-1:0] op_frac;
  logic [EXP_W-1:0]  unit_exp;
  logic [MANT_W-1:0] rnd_mant;
  rhw_work_t         last;

  assign ce       = !out_valid_r || !out_stall;
  assign in_stall = !ce;

  // operand decode and special cases
  always_comb begin
    op_sign  = in_operand_bits[WORD_W-1];
    op_exp   = in_operand_bits[WORD_W-2:MANT_W];
    op_frac  = in_operand_bits[MANT_W-1:0];
    unit_exp = EXP_UNIT_BASE - op_exp;

    front                  = '0;
    front.valid            = in_valid;
    front.rem              = {1'b1, {(REM_W-1){1'b0}}};
    front.div              = {1'b1, op_frac};
    front.quo              = '0;
    front.side.sign        = op_sign;
    front.side.res_exp     = EXP_FRAC_BASE - op_exp;
    front.side.special     = 1'b1;
    front.side.special_val = {op_sign, {(WORD_W-1){1'b0}}};

    if (op_exp == EXP_ONES && op_frac != '0) begin
      front.side.special_val = {1'b0, in_operand_bits[WORD_W-2:0]};
    end else if (op_exp == '0) begin
      front.side.special_val = {op_sign, EXP_ONES, {MANT_W{1'b0}}};
    end else if (op_exp == EXP_ONES) begin
      front.side.special_val = {op_sign, {(WORD_W-1){1'b0}}};
    end else if (op_frac == '0) begin
      if (unit_exp != '0) begin
        front.side.special_val = {op_sign, unit_exp, {MANT_W{1'b0}}};
      end
    end else if (op_exp < EXP_FRAC_BASE) begin
      front.side.special = 1'b0;
    end
  end

  assign chain[0] = front;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ce       (ce),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // rounding and packing
  always_comb begin
    last     = chain[NUM_CELLS];
    rnd_mant = last.quo[QUO_W-2:1] + {{(MANT_W-1){1'b0}}, last.quo[0]};
    if (last.side.special) begin
      out_data_nxt = last.side.special_val;
    end else begin
      out_data_nxt = {last.side.sign, last.side.res_exp,
                      rnd_mant[MANT_W-1:LOW_W], {LOW_W{1'b0}}};
    end
    out_valid_nxt = ce ? last.valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_data_r;

  a_low_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_bits[LOW_W-1:0] == '0 ||
                   out_result_bits[WORD_W-2:MANT_W] == EXP_ONES))
    else $error("low word not cleared on a non-nan result");

  a_nan_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_bits[WORD_W-2:MANT_W] == EXP_ONES &&
     out_result_bits[MANT_W-1:0] != '0) |-> !out_result_bits[WORD_W-1])
    else $error("nan result with sign set");

  a_quo_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (chain[NUM_CELLS].valid && !chain[NUM_CELLS].side.special) |->
      chain[NUM_CELLS].quo[QUO_W-1])
    else $error("quotient leading bit clear");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output blocked");

endmodule

@@ tb/sv/tb_fp64_reciprocal_high_word.sv @@
// testbench for fp64_reciprocal_high_word: directed and random binary64 words
// with random idling on both sides, checked against a real-arithmetic predictor
// depends on rhw_pkg and the fp64_reciprocal_high_word rtl
`timescale 1ns / 1ps

module tb_fp64_reciprocal_high_word;
  import rhw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_WORD   = 120;
  localparam int CALM_TAIL      = 60;
  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ABS_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HIGH_MASK = 64'hFFFF_FFFF_0000_0000;
  localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [WORD_W-1:0] in_operand_bits;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_result_bits;

  logic [63:0] operand_q[$];
  logic [63:0] recip_q[$];
  int          errors;
  int          words_sent;
  int          idle_count;

  fp64_reciprocal_high_word uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operand_bits(in_operand_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_bits(out_result_bits)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [63:0] recip_high_word(logic [63:0] x);
    logic [10:0] ex;
    logic [63:0] q;
    ex = x[62:52];
    if (ex == EXP_ONES && x[51:0] != 52'd0) return x & ABS_MASK;
    if (ex == 11'd0) return (x & SIGN_BIT) | POS_INF;
    q = $realtobits(1.0 / $bitstoreal(x));
    if (q[62:52] == 11'd0) return q & SIGN_BIT;
    return q & HIGH_MASK;
  endfunction

  function automatic logic [63:0] random_operand();
    logic [63:0] w;
    int          pick;
    w = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2:  ;
      3:        w[62:52] = 11'd0;
      4:        w[62:52] = EXP_ONES;
      5:        w[62:0] = 63'd0;
      6, 7:     w[62:52] = 11'($urandom_range(2040, 2046));
      8, 9:     w[62:52] = 11'($urandom_range(1, 6));
      10:       w[51:0] = 52'd0;
      11:       w[31:0] = 32'd0;
      default:  w[62:52] = 11'($urandom_range(900, 1150));
    endcase
    return w;
  endfunction

  task automatic report_mismatch(logic [63:0] got, logic [63:0] want);
    $display("mismatch: result_bits %h, expected %h", got, want);
    errors++;
  endtask

  // driver
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operand_bits <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        recip_q.push_back(recip_high_word(in_operand_bits));
        words_sent <= words_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (operand_q.size() > 0) begin
          in_valid <= 1'b1;
          in_operand_bits <= operand_q.pop_front();
          if (operand_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            gap_left <= $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  int stall_left;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (!hold_done && words_sent >= HOLD_AT_WORD) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if (operand_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (recip_q.size() == 0) begin
        $display("unexpected word: result_bits %h", out_result_bits);
        errors++;
      end else begin
        if (out_result_bits !== recip_q[0]) report_mismatch(out_result_bits, recip_q[0]);
        void'(recip_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    idle_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operand_bits = '0;
    out_stall = 1'b0;
    // zeros, subnormals, extremes of the normal range, 1.0, -1.0, 3.0, -7.0, infinities, nans
    operand_q.push_back(64'h0000_0000_0000_0000);
    operand_q.push_back(64'h8000_0000_0000_0000);
    operand_q.push_back(64'h0000_0000_0000_0001);
    operand_q.push_back(64'h800F_FFFF_FFFF_FFFF);
    operand_q.push_back(64'h0010_0000_0000_0000);
    operand_q.push_back(64'h8010_0000_0000_0001);
    operand_q.push_back(64'h7FEF_FFFF_FFFF_FFFF);
    operand_q.push_back(64'hFFEF_FFFF_FFFF_FFFF);
    operand_q.push_back(64'h7FD0_0000_0000_0000);
    operand_q.push_back(64'h7FE0_0000_0000_0000);
    operand_q.push_back(64'h7FDF_FFFF_FFFF_FFFF);
    operand_q.push_back(64'h3FF0_0000_0000_0000);
    operand_q.push_back(64'hBFF0_0000_0000_0000);
    operand_q.push_back(64'h4008_0000_0000_0000);
    operand_q.push_back(64'hC01C_0000_0000_0000);
    operand_q.push_back(64'h3FF0_0000_0000_0001);
    operand_q.push_back(64'h7FF0_0000_0000_0000);
    operand_q.push_back(64'hFFF0_0000_0000_0000);
    operand_q.push_back(64'h7FF8_0000_0000_0000);
    operand_q.push_back(64'h7FF0_0000_0000_0001);
    operand_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    operand_q.push_back(64'hFFF4_5555_AAAA_0000);
    for (int i = 0; i < 450; i++) operand_q.push_back(random_operand());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (operand_q.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (recip_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ fp64_reciprocal_high_word.f @@
hdl/rhw_pkg.sv
hdl/rhw_cell.sv
hdl/fp64_reciprocal_high_word.sv
tb/sv/tb_fp64_reciprocal_high_word.sv
